// ===== src/bdq_pkg.sv =====
// Shared types and codes for the bounded deque with positional delete.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_INS_FRONT  = 2'd0;
    localparam t_action ACT_INS_END    = 2'd1;
    localparam t_action ACT_DEL_FIRST  = 2'd2;
    localparam t_action ACT_DEL_BEFORE = 2'd3;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_BAD       = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } t_op;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  removed_value;
        logic [LEN_W-1:0]           length;
    } t_result;

endpackage

// ===== src/bdq_core.sv =====
// Entry array and fill count of the deque, with the combinational update logic.
`timescale 1ns / 1ps

module bdq_core #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  bdq_pkg::t_op      i_op,
    output bdq_pkg::t_result  o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [bdq_pkg::VALUE_W-1:0] r_entries [CAPACITY];
    logic signed [bdq_pkg::VALUE_W-1:0] n_entries [CAPACITY];
    logic [CW-1:0]                      r_fill;
    logic [CW-1:0]                      n_fill;

    logic                    do_front;
    logic                    do_end;
    logic                    do_del;
    logic [IW-1:0]           del_idx;
    logic [bdq_pkg::POS_W-1:0] pos_m2;
    bdq_pkg::t_status        status;

    assign pos_m2 = i_op.position - bdq_pkg::POS_W'(2);

    always_comb begin
        do_front = 1'b0;
        do_end   = 1'b0;
        do_del   = 1'b0;
        del_idx  = '0;
        status   = bdq_pkg::ST_DONE;
        n_fill   = r_fill;
        case (i_op.action)
            bdq_pkg::ACT_INS_FRONT,
            bdq_pkg::ACT_INS_END: begin
                if (r_fill >= CW'(CAPACITY)) begin
                    status = bdq_pkg::ST_FULL;
                end else begin
                    do_front = (i_op.action == bdq_pkg::ACT_INS_FRONT);
                    do_end   = (i_op.action == bdq_pkg::ACT_INS_END);
                    n_fill   = r_fill + CW'(1);
                end
            end
            bdq_pkg::ACT_DEL_FIRST: begin
                if (r_fill == '0) begin
                    status = bdq_pkg::ST_BAD;
                end else begin
                    do_del = 1'b1;
                    n_fill = r_fill - CW'(1);
                end
            end
            default: begin
                if (i_op.position <= bdq_pkg::POS_W'(1) || r_fill == '0) begin
                    status = bdq_pkg::ST_BAD;
                end else if ({1'b0, i_op.position} >
                             (17'(r_fill) + 17'd1)) begin
                    status = bdq_pkg::ST_NOT_FOUND;
                end else begin
                    do_del  = 1'b1;
                    del_idx = pos_m2[IW-1:0];
                    n_fill  = r_fill - CW'(1);
                end
            end
        endcase
    end

    // Every lane picks its next word from itself, a neighbor or the incoming value, all in parallel.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_lane
        always_comb begin
            n_entries[k] = r_entries[k];
            if (do_front) begin
                if (k == 0) begin
                    n_entries[k] = i_op.value;
                end else begin
                    n_entries[k] = r_entries[(k > 0) ? k - 1 : 0];
                end
            end else if (do_end) begin
                if (CW'(k) == r_fill) begin
                    n_entries[k] = i_op.value;
                end
            end else if (do_del) begin
                if (k < CAPACITY - 1 && IW'(k) >= del_idx) begin
                    n_entries[k] = r_entries[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_en) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entries <= n_entries;
        end
    end

    assign o_result.status        = status;
    assign o_result.removed_value = do_del ? r_entries[del_idx] : '0;
    assign o_result.length        = bdq_pkg::LEN_W'(n_fill);

endmodule

// ===== src/bounded_deque_positional_delete.sv =====
// Top level of the bounded deque: input register, update core and result register.
// Throughput: one word per cycle while the result side does not stall, helped by the parallel shift of the entry lanes.
// The input register takes a new word while a result waits, until both stages are full.
// Reset (synchronous, active low) empties the list and clears both stage valids;
// entry contents are not cleared and never reach an output before they are written.
`timescale 1ns / 1ps

module bounded_deque_positional_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bdq_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  i_value,
    input  logic [bdq_pkg::POS_W-1:0]           i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bdq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [bdq_pkg::VALUE_W-1:0]  o_removed_value,
    output logic [bdq_pkg::LEN_W-1:0]           o_length
);

    // Stage one holds the incoming word; stage two is the result register.
    logic              r_in_valid;
    bdq_pkg::t_op      r_op;
    logic              r_out_valid;
    bdq_pkg::t_result  r_result;
    bdq_pkg::t_result  core_result;

    logic in_take;
    logic s2_load;

    // The held word moves on, and the list updates, whenever the result
    // register is empty or its word is being taken this cycle.
    assign s2_load    = r_in_valid && (!r_out_valid || !i_out_stall);
    // Stall only when a word is held and it cannot move on.
    assign o_in_stall = r_in_valid && !s2_load;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s2_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op.action   <= i_action;
            r_op.value    <= i_value;
            r_op.position <= i_position;
        end
    end

    // The core changes its state only when its result is captured below, so
    // each word sees the list exactly as the word before it left it.
    bdq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s2_load),
        .i_op     (r_op),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_result.status;
    assign o_removed_value = r_result.removed_value;
    assign o_length        = r_result.length;

endmodule

// ===== src/bdq_checker.sv =====
// Port-level assertions for the bounded deque, bound to the top level.
`timescale 1ns / 1ps

module bdq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [bdq_pkg::STATUS_W-1:0]        o_status,
    input logic signed [bdq_pkg::VALUE_W-1:0]  o_removed_value,
    input logic [bdq_pkg::LEN_W-1:0]           o_length
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_fail_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != bdq_pkg::ST_DONE |-> o_removed_value == '0)
        else $error("failed action reports a removed word");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bdq_pkg::ST_FULL
            |-> o_length == bdq_pkg::LEN_W'(CAPACITY))
        else $error("full status with a list that is not full");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_removed_value) && $stable(o_length))
        else $error("stalled result changed");

endmodule

bind bounded_deque_positional_delete bdq_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (.*);

// ===== tb/bdq_result_checker.sv =====
// Result checker for the bounded deque: predicts each result word and compares it.
`timescale 1ns / 1ps

module bdq_result_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [bdq_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  i_value,
    input  logic [bdq_pkg::POS_W-1:0]           i_position,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [bdq_pkg::STATUS_W-1:0]        i_status,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  i_removed_value,
    input  logic [bdq_pkg::LEN_W-1:0]           i_length,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_peak_fill,
    output int                                  o_full_hits
);

    // Shadow copy of the list: lane[0] is the front, lane[held-1] the end.
    logic signed [bdq_pkg::VALUE_W-1:0] lane [CAPACITY];
    int                                 held;
    bdq_pkg::t_result                   expected_q [$];
    int                                 fails;
    int                                 checked;
    int                                 peak;
    int                                 full_hits;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s is %0d, expected %0d", checked, what, got, want);
        fails++;
    endtask

    // Removes one entry and closes the gap behind it.
    function automatic logic signed [bdq_pkg::VALUE_W-1:0] pull_lane(input int slot);
        logic signed [bdq_pkg::VALUE_W-1:0] taken;
        taken = lane[slot];
        for (int i = slot; i + 1 < held; i++) lane[i] = lane[i + 1];
        held--;
        return taken;
    endfunction

    function automatic bdq_pkg::t_result advance_deque(input bdq_pkg::t_op op);
        bdq_pkg::t_result r;
        r.status        = bdq_pkg::ST_DONE;
        r.removed_value = '0;
        case (op.action)
            bdq_pkg::ACT_INS_FRONT: begin
                if (held >= CAPACITY) begin
                    r.status = bdq_pkg::ST_FULL;
                end else begin
                    for (int i = held; i > 0; i--) lane[i] = lane[i - 1];
                    lane[0] = op.value;
                    held++;
                end
            end
            bdq_pkg::ACT_INS_END: begin
                if (held >= CAPACITY) begin
                    r.status = bdq_pkg::ST_FULL;
                end else begin
                    lane[held] = op.value;
                    held++;
                end
            end
            bdq_pkg::ACT_DEL_FIRST: begin
                if (held == 0) r.status = bdq_pkg::ST_BAD;
                else r.removed_value = pull_lane(0);
            end
            default: begin
                if (op.position <= 1 || held == 0) r.status = bdq_pkg::ST_BAD;
                else if (int'(op.position) > held + 1) r.status = bdq_pkg::ST_NOT_FOUND;
                else r.removed_value = pull_lane(int'(op.position) - 2);
            end
        endcase
        r.length = bdq_pkg::LEN_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        bdq_pkg::t_op     op;
        bdq_pkg::t_result got;
        bdq_pkg::t_result want;
        if (!i_rst_n) begin
            held = 0;
            expected_q.delete();
        end else begin
            // Predict first so that the expected word is queued before any result is compared.
            if (i_in_valid && !i_in_stall) begin
                op.action   = i_action;
                op.value    = i_value;
                op.position = i_position;
                want        = advance_deque(op);
                expected_q.push_back(want);
                if (want.status == bdq_pkg::ST_FULL) full_hits++;
                if (held > peak) peak = held;
            end
            if (i_out_valid && !i_out_stall) begin
                got.status        = i_status;
                got.removed_value = i_removed_value;
                got.length        = i_length;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result word, status", got.status, -1);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.removed_value !== want.removed_value)
                        report_mismatch("removed value", longint'(got.removed_value),
                                        longint'(want.removed_value));
                    if (got.length !== want.length)
                        report_mismatch("length", got.length, want.length);
                end
                checked++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_peak_fill  <= peak;
        o_full_hits  <= full_hits;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the bounded deque testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_WORDS = 1700;
    localparam int BURST_LEN    = 32;
    // Longest legal quiet stretch is a long input gap plus a long stall; this limit
    // leaves a wide margin over it.
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    bdq_pkg::t_action                    i_action;
    logic signed [bdq_pkg::VALUE_W-1:0]  i_value;
    logic [bdq_pkg::POS_W-1:0]           i_position;
    logic                                o_out_valid;
    logic                                i_out_stall;
    bdq_pkg::t_status                    o_status;
    logic signed [bdq_pkg::VALUE_W-1:0]  o_removed_value;
    logic [bdq_pkg::LEN_W-1:0]           o_length;

    int fail_count;
    int pending;
    int checked;
    int peak_fill;
    int full_hits;
    int words_sent;
    int directed_words;
    bit calm;

    bounded_deque_positional_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_length       (o_length)
    );

    bdq_result_checker #(
        .CAPACITY(CAPACITY)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_position     (i_position),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_removed_value(o_removed_value),
        .i_length       (o_length),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_peak_fill    (peak_fill),
        .o_full_hits    (full_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Length of an idle or stall stretch: mostly none or short, now and then long.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drives one word and returns once the block has taken it. Inputs move only on the
    // falling edge; when no gap is wanted, valid simply stays high into the next word,
    // so it is never lowered and raised within one time step.
    task automatic send_word(input bdq_pkg::t_action act,
                             input logic signed [bdq_pkg::VALUE_W-1:0] val,
                             input logic [bdq_pkg::POS_W-1:0] pos);
        int gap;
        gap = calm ? 0 : idle_span();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // A value to store: mostly uniform over all 32 bits, sometimes one of the extremes.
    function automatic logic signed [bdq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Positions 2..18 cover every index that can exist plus the first ones beyond the
    // end; the rest hit the rejected low positions and the far end of the 16-bit field.
    function automatic logic [bdq_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return bdq_pkg::POS_W'($urandom_range(2, CAPACITY + 2));
        if (r < 80) return bdq_pkg::POS_W'($urandom_range(0, 1));
        if (r < 95) return bdq_pkg::POS_W'($urandom);
        return '1;
    endfunction

    // Result side back-pressure: runs of stall of random length separated by open
    // stretches, now and then a long open stretch so the block also runs at full rate.
    initial begin : result_backpressure
        int hold;
        i_out_stall = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (i_out_stall) begin
                i_out_stall <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 6);
            end else begin
                i_out_stall <= 1'b1;
                hold = idle_span();
            end
        end
    end

    // The run ends as failed if neither channel moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int               mode;
        int               r;
        bdq_pkg::t_action act;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = bdq_pkg::ACT_INS_FRONT;
        i_value    = '0;
        i_position = '0;
        calm       = 1'b0;
        words_sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Deletes on the empty list are refused first, then a five-entry
        // list built from the value extremes is taken apart through each delete path.
        send_word(bdq_pkg::ACT_DEL_FIRST,  32'sd5, 16'd0);
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd5, 16'd2);
        send_word(bdq_pkg::ACT_INS_FRONT,  32'sh7FFF_FFFF, 16'd0);
        send_word(bdq_pkg::ACT_INS_END,    32'sh8000_0000, 16'hFFFF);
        send_word(bdq_pkg::ACT_INS_FRONT,  -32'sd1, 16'd0);
        send_word(bdq_pkg::ACT_INS_END,    32'sd0, 16'd0);
        send_word(bdq_pkg::ACT_INS_END,    32'sh5A5A_A5A5, 16'd0);
        // Positions 0 and 1 are invalid, a position past length+1 is not found.
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'd0);
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'd1);
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'hFFFF);
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'd7);
        // Position length+1 removes the last entry, a middle one removes from inside,
        // position 2 removes the first entry.
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'd6);
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'd3);
        send_word(bdq_pkg::ACT_DEL_BEFORE, 32'sd0, 16'd2);
        send_word(bdq_pkg::ACT_DEL_FIRST,  32'sd0, 16'd0);
        send_word(bdq_pkg::ACT_DEL_FIRST,  32'sd0, 16'd0);
        directed_words = words_sent;

        // Random part in bursts. A filling burst is mostly inserts and drives the list
        // into the full case, a draining burst mostly deletes and empties it, and a mixed
        // burst wanders in between. Some bursts run without any input gaps.
        while (words_sent < directed_words + RANDOM_WORDS) begin
            mode = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            repeat (BURST_LEN) begin
                r = $urandom_range(0, 99);
                if ((mode == 0 && r < 78) || (mode == 1 && r < 22) || (mode == 2 && r < 50))
                    act = ($urandom_range(0, 1) == 0) ? bdq_pkg::ACT_INS_FRONT
                                                      : bdq_pkg::ACT_INS_END;
                else
                    act = ($urandom_range(0, 99) < 35) ? bdq_pkg::ACT_DEL_FIRST
                                                       : bdq_pkg::ACT_DEL_BEFORE;
                send_word(act, pick_value(), pick_position());
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Every result must come back; the watchdog covers one that never does.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d directed, the rest random); %0d results checked.",
                 words_sent, directed_words, checked);
        $display("The list peaked at %0d entries and refused %0d inserts while full.",
                 peak_fill, full_hits);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches found", fail_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
